[rtl/rpd_pkg.sv]
// Package for the 24-bit pixel run-length decoder.
// Holds the result record type and the counter constants; no dependencies.
package rpd_pkg;

   localparam int unsigned PIXEL_W  = 24;
   localparam int unsigned REPEAT_W = 8;
   localparam int unsigned RAW_W    = 26;
   localparam int unsigned COUNT_W  = 27;
   localparam int unsigned ADD_W    = 10;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [1:0]         LAST_PHASE  = 2'd2;
   localparam logic [ADD_W-1:0]   PIXEL_BYTES = 10'd3;

   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel_value;
      logic [REPEAT_W-1:0] repeat_res;
      logic                frame_end;
      logic                length_ok;
   } rpd_result_type;

endpackage

[rtl/rle_pixel24_decoder_unit.sv]
// Top level of the 24-bit pixel run-length decoder.
// Depends on rpd_pkg, rpd_decode and rpd_out_reg.
//
//   channel   direction  payload
//   req_      in         data_byte[7:0], last_byte
//   rsp_      out        pixel_value[23:0], repeat_res[7:0], frame_end, length_ok
//   csr_      in         raw_length[25:0], write only
//
// One request per cycle unless a result stalls; a request that gives a result
// shows it in the next cycle. The single result register sets the figure: the
// next request is taken while a result waits, if rsp_ready takes it that cycle.
// Reset is synchronous and returns the decoder to the start of a frame.
// A stalled result holds req_ready low until it is taken.
module rle_pixel24_decoder_unit import rpd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [RAW_W-1:0]     csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIXEL_W-1:0]   rsp_pixel_value,
   output logic [REPEAT_W-1:0]  rsp_repeat_res,
   output logic                 rsp_frame_end,
   output logic                 rsp_length_ok
);

   logic           take;
   logic           res_valid;
   rpd_result_type res;
   rpd_result_type out_res;

   assign take = req_valid && req_ready;

   rpd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .res_valid   (res_valid),
      .res         (res)
   );

   rpd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_res    (res),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_res   (out_res)
   );

   assign rsp_pixel_value = out_res.pixel_value;
   assign rsp_repeat_res  = out_res.repeat_res;
   assign rsp_frame_end   = out_res.frame_end;
   assign rsp_length_ok   = out_res.length_ok;

`ifndef NO_ASSERTIONS
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow the result register");

   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_repeat_res == 8'd0 |-> rsp_frame_end && rsp_pixel_value == '0)
      else $error("zero repeat outside an end marker");

   a_ok_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_ok |-> rsp_frame_end)
      else $error("length_ok without frame_end");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      take && req_last_byte |=> rsp_valid && rsp_frame_end)
      else $error("last request gave no frame end result");
`endif

endmodule

[rtl/rpd_decode.sv]
// Byte decoder: frame state, raw length register and result computation.
// Depends on rpd_pkg.
module rpd_decode import rpd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [RAW_W-1:0]     csr_wr_data,
   input  logic                 take,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   output logic                 res_valid,
   output rpd_result_type       res
);

   logic [RAW_W-1:0]   raw_length_ff;
   logic [1:0]         phase_ff, phase_in;
   logic [15:0]        partial_ff, partial_in;
   logic [PIXEL_W-1:0] held_ff, held_in;
   logic               match_ff, match_in;
   logic               expect_ff, expect_in;
   logic               fresh_ff, fresh_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               have;
   logic [PIXEL_W-1:0] pix;
   logic [REPEAT_W-1:0] rep;
   logic [ADD_W-1:0]   add_n;
   logic [COUNT_W:0]   sum;
   logic [COUNT_W-1:0] count_new;

   always_comb begin
      phase_in   = phase_ff;
      partial_in = partial_ff;
      held_in    = held_ff;
      match_in   = match_ff;
      expect_in  = expect_ff;
      fresh_in   = fresh_ff;
      have       = 1'b0;
      pix        = '0;
      rep        = '0;
      add_n      = '0;
      if (expect_ff) begin
         expect_in = 1'b0;
         fresh_in  = 1'b1;
         match_in  = 1'b0;
         if (data_byte != 8'd0) begin
            have  = 1'b1;
            pix   = held_ff;
            rep   = data_byte;
            add_n = {2'b00, data_byte} + {1'b0, data_byte, 1'b0};
         end
      end else if (phase_ff < LAST_PHASE) begin
         partial_in = {partial_ff[7:0], data_byte};
         phase_in   = phase_ff + 2'd1;
      end else begin
         pix        = {partial_ff, data_byte};
         phase_in   = '0;
         partial_in = '0;
         if (fresh_ff || pix == held_ff) begin
            match_in  = ~match_ff;
            expect_in = match_ff;
         end else begin
            match_in = 1'b0;
         end
         fresh_in = 1'b0;
         held_in  = pix;
         have     = 1'b1;
         rep      = 8'd1;
         add_n    = PIXEL_BYTES;
      end
      sum       = {1'b0, count_ff} + {{(COUNT_W+1-ADD_W){1'b0}}, add_n};
      count_new = (sum >= {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
      count_in  = count_new;
      if (last_byte) begin
         phase_in   = '0;
         partial_in = '0;
         held_in    = '0;
         match_in   = 1'b0;
         expect_in  = 1'b0;
         fresh_in   = 1'b1;
         count_in   = '0;
      end
      res_valid       = take && (have || last_byte);
      res.pixel_value = pix;
      res.repeat_res  = rep;
      res.frame_end   = last_byte;
      res.length_ok   = last_byte && (count_new == {1'b0, raw_length_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_length_ff <= '0;
         phase_ff      <= '0;
         partial_ff    <= '0;
         held_ff       <= '0;
         match_ff      <= 1'b0;
         expect_ff     <= 1'b0;
         fresh_ff      <= 1'b1;
         count_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            raw_length_ff <= csr_wr_data;
         end
         if (take) begin
            phase_ff   <= phase_in;
            partial_ff <= partial_in;
            held_ff    <= held_in;
            match_ff   <= match_in;
            expect_ff  <= expect_in;
            fresh_ff   <= fresh_in;
            count_ff   <= count_in;
         end
      end
   end

endmodule

[rtl/rpd_out_reg.sv]
// Result register between the decoder and the response channel.
// Depends on rpd_pkg.
module rpd_out_reg import rpd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  rpd_result_type       in_res,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rpd_result_type       out_res
);

   logic           valid_ff;
   rpd_result_type res_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         res_ff <= in_res;
      end
   end

endmodule

[test/rpd_checker.sv]
// Checker for the 24-bit pixel run-length decoder: watches the request, result and
// register ports, predicts each result and compares it field by field.
// Depends on rpd_pkg for the result record and the counter constants.
module rpd_checker import rpd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [RAW_W-1:0]     csr_wr_data,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [PIXEL_W-1:0]   rsp_pixel_value,
   input  logic [REPEAT_W-1:0]  rsp_repeat_res,
   input  logic                 rsp_frame_end,
   input  logic                 rsp_length_ok,
   output int unsigned          fail_count,
   output int unsigned          pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [RAW_W-1:0]   frame_bytes_cfg;
   logic [1:0]         byte_slot;
   logic [15:0]        pixel_head;
   logic [PIXEL_W-1:0] last_pixel;
   logic               one_match;
   logic               count_next;
   logic               run_restart;
   logic [COUNT_W-1:0] decoded_total;
   rpd_result_type     expected_results[$];

   initial begin
      fail_count = 0;
      pending_results = 0;
   end

   task automatic restart_frame();
      byte_slot = '0;
      pixel_head = '0;
      last_pixel = '0;
      one_match = 1'b0;
      count_next = 1'b0;
      run_restart = 1'b1;
      decoded_total = '0;
   endtask

   function automatic logic [COUNT_W-1:0] add_saturating(input logic [COUNT_W-1:0] total,
                                                        input int unsigned n);
      logic [COUNT_W:0] sum;
      sum = {1'b0, total} + (COUNT_W+1)'(n);
      return (sum >= {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic last);
      rpd_result_type r;
      logic           produced;
      r = '0;
      produced = 1'b0;
      if (count_next) begin
         count_next = 1'b0;
         run_restart = 1'b1;
         one_match = 1'b0;
         if (b != 8'h00) begin
            produced = 1'b1;
            r.pixel_value = last_pixel;
            r.repeat_res = b;
            decoded_total = add_saturating(decoded_total, 32'(PIXEL_BYTES * b));
         end
      end else if (byte_slot < LAST_PHASE) begin
         pixel_head = {pixel_head[7:0], b};
         byte_slot = byte_slot + 2'd1;
      end else begin
         r.pixel_value = {pixel_head, b};
         byte_slot = '0;
         pixel_head = '0;
         if (run_restart || r.pixel_value == last_pixel) begin
            if (one_match) begin
               one_match = 1'b0;
               count_next = 1'b1;
            end else begin
               one_match = 1'b1;
            end
         end else begin
            one_match = 1'b0;
         end
         run_restart = 1'b0;
         last_pixel = r.pixel_value;
         produced = 1'b1;
         r.repeat_res = 8'd1;
         decoded_total = add_saturating(decoded_total, 32'(PIXEL_BYTES));
      end
      if (produced || last) begin
         r.frame_end = last;
         r.length_ok = last && (decoded_total == {1'b0, frame_bytes_cfg});
         expected_results.push_back(r);
      end
      if (last)
         restart_frame();
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rpd_result_type want;
      if (reset) begin
         frame_bytes_cfg = '0;
         restart_frame();
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               $error("pixel_value with no request pending: expected none, actual %0h",
                      rsp_pixel_value);
            end else begin
               want = expected_results.pop_front();
               compare_field("pixel_value", 32'(want.pixel_value), 32'(rsp_pixel_value));
               compare_field("repeat_res", 32'(want.repeat_res), 32'(rsp_repeat_res));
               compare_field("frame_end", 32'(want.frame_end), 32'(rsp_frame_end));
               compare_field("length_ok", 32'(want.length_ok), 32'(rsp_length_ok));
            end
         end
         if (csr_wr_en)
            frame_bytes_cfg = csr_wr_data;
         if (req_valid && req_ready)
            decode_byte(req_data_byte, req_last_byte);
      end
      pending_results <= expected_results.size();
   end

endmodule

[test/testbench.sv]
// Top of the run-length decoder test: drives directed and random frames
// with random idling on both channels and prints the verdict.
// Depends on rpd_pkg, rle_pixel24_decoder_unit and rpd_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rpd_pkg::*;

   typedef enum int {END_PIXEL, END_MARKER, END_COUNT, END_ZERO_COUNT} frame_ending_type;

   localparam int unsigned RANDOM_REQUESTS  = 1350;
   localparam int unsigned QUIET_REQUESTS   = 200;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES    = 4;

   // bit 8 marks the last byte of a frame
   localparam logic [8:0] OPENING_BYTES [25] = '{
      9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h000,
      9'h001, 9'h002, 9'h003, 9'h001, 9'h102,
      9'h080, 9'h000, 9'h001, 9'h080, 9'h000, 9'h001, 9'h1FF,
      9'h07F, 9'h0FE, 9'h000, 9'h07F, 9'h0FE, 9'h100
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [RAW_W-1:0]     csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_data_byte = '0;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PIXEL_W-1:0]   rsp_pixel_value;
   logic [REPEAT_W-1:0]  rsp_repeat_res;
   logic                 rsp_frame_end;
   logic                 rsp_length_ok;
   int unsigned          fail_count;
   int unsigned          pending_results;

   int unsigned          tx_gap_pct = 0;
   int unsigned          rx_stall_pct = 0;
   bit                   long_hold_req = 1'b0;
   int unsigned          request_count = 0;
   logic [PIXEL_W-1:0]   prev_pixel = '0;
   bit                   run_fresh = 1'b1;

   rle_pixel24_decoder_unit i_dut (.*);

   rpd_checker i_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   always begin
      @(posedge clock);
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         rsp_ready <= 1'b0;
         repeat (LONG_HOLD_CYCLES) @(posedge clock);
         rsp_ready <= 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(99, 0) < rx_stall_pct) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic offer_byte(input logic [7:0] b, input logic last);
      if (tx_gap_pct != 0 && $urandom_range(99, 0) < tx_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      request_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_raw_length(input logic [RAW_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [PIXEL_W-1:0] pick_pixel(input bit avoid_prev);
      logic [PIXEL_W-1:0] p;
      do begin
         case ($urandom_range(3, 0))
            0:       p = '0;
            1:       p = '1;
            default: p = PIXEL_W'($urandom);
         endcase
      end while (avoid_prev && p == prev_pixel);
      return p;
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] p, input logic last);
      offer_byte(p[23:16], 1'b0);
      offer_byte(p[15:8], 1'b0);
      offer_byte(p[7:0], last);
      prev_pixel = p;
      run_fresh = 1'b0;
   endtask

   // two copies after a count, three after a lone pixel, then the count byte
   task automatic send_run(input logic [7:0] count, input logic last);
      logic [PIXEL_W-1:0] p;
      bit                 lead;
      lead = !run_fresh;
      p = pick_pixel(lead);
      send_pixel(p, 1'b0);
      send_pixel(p, 1'b0);
      if (lead)
         send_pixel(p, 1'b0);
      offer_byte(count, last);
      run_fresh = 1'b1;
   endtask

   task automatic send_marker();
      int unsigned n;
      n = $urandom_range(2, 1);
      for (int unsigned j = 1; j <= n; j++)
         offer_byte(8'($urandom), j == n);
   endtask

   // decodes to exactly units pixels' worth of bytes
   task automatic send_shaped_frame(input int unsigned units);
      frame_ending_type ending;
      int unsigned      rest;
      int unsigned      base;
      int unsigned      cmax;
      int unsigned      c;
      bit               done;
      ending = frame_ending_type'($urandom_range(3, 0));
      rest = units;
      done = 1'b0;
      run_fresh = 1'b1;
      while (!done) begin
         base = run_fresh ? 2 : 3;
         if (ending == END_COUNT && rest > base && rest - base <= 255
             && $urandom_range(1, 0) == 1) begin
            send_run(8'(rest - base), 1'b1);
            done = 1'b1;
         end else if (ending == END_ZERO_COUNT && rest == base) begin
            send_run(8'h00, 1'b1);
            done = 1'b1;
         end else if (ending == END_PIXEL && rest == 1) begin
            send_pixel(pick_pixel(1'b1), 1'b1);
            done = 1'b1;
         end else if (rest == 0) begin
            send_marker();
            done = 1'b1;
         end else if (rest >= base && (rest > 40 || $urandom_range(1, 0) == 1)) begin
            cmax = (rest - base > 255) ? 255 : rest - base;
            c = (rest > 40) ? $urandom_range(cmax, cmax / 2) : $urandom_range(cmax, 0);
            send_run(8'(c), 1'b0);
            rest -= base + c;
         end else begin
            send_pixel(pick_pixel(1'b1), 1'b0);
            rest--;
         end
      end
   endtask

   task automatic send_noise_frame();
      int unsigned len;
      logic [7:0]  b;
      len = $urandom_range(24, 1);
      for (int unsigned j = 1; j <= len; j++) begin
         case ($urandom_range(3, 0))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            2:       b = 8'h5A;
            default: b = 8'($urandom);
         endcase
         offer_byte(b, j == len);
      end
   endtask

   initial begin
      int unsigned      random_start;
      int unsigned      phase_index;
      int unsigned      phase_units;
      logic [RAW_W-1:0] raw_value;
      random_start = 0;
      phase_index = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      rx_stall_pct = 20;
      write_raw_length('0);
      offer_byte(8'h00, 1'b1);
      wait_drained();
      write_raw_length(RAW_W'(9));
      for (int i = 0; i < 25; i++)
         offer_byte(OPENING_BYTES[i][7:0], OPENING_BYTES[i][8]);
      wait_drained();

      random_start = request_count;
      while (request_count - random_start < RANDOM_REQUESTS) begin
         case ($urandom_range(4, 0))
            0:       phase_units = 0;
            1:       phase_units = $urandom_range(12, 1);
            2:       phase_units = $urandom_range(120, 13);
            3:       phase_units = $urandom_range(2000, 300);
            default: phase_units = $urandom_range(40, 1);
         endcase
         raw_value = ($urandom_range(4, 0) == 0) ? RAW_W'($urandom) : RAW_W'(3 * phase_units);
         write_raw_length(raw_value);
         if (request_count - random_start + QUIET_REQUESTS >= RANDOM_REQUESTS) begin
            tx_gap_pct = 0;
            rx_stall_pct = 0;
         end else begin
            tx_gap_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(35, 5);
            rx_stall_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(35, 5);
         end
         if (phase_index == 1)
            long_hold_req = 1'b1;
         repeat ($urandom_range(8, 3)) begin
            if ($urandom_range(4, 0) == 0)
               send_noise_frame();
            else
               send_shaped_frame(($urandom_range(1, 0) == 0) ? phase_units
                                                          : $urandom_range(phase_units + 4, 0));
         end
         wait_drained();
         phase_index++;
      end

      if (fail_count == 0 && pending_results == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
